// ----- hw/rtl/hill_cipher_mod26_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Hill cipher unit assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef HILL_CIPHER_MOD26_UNIT_MACROS_SVH
`define HILL_CIPHER_MOD26_UNIT_MACROS_SVH

// same-cycle implication
`define HCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Hill cipher package
// Widths, register indexes, controller/datapath interface types and the
// small mod-26 helpers used by the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcm_pkg;

  localparam int LETTER_W  = 5;
  localparam int KEY_W     = 45;
  localparam int CFG_IDX_W = 2;
  localparam int MODULUS   = 26;
  // floor(2^12 / 26); quotient estimate is at most one low for 11-bit values
  localparam int RECIP     = 157;
  // 25 * 26, keeps a cofactor difference non-negative
  localparam int COF_BIAS  = 650;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  typedef struct packed {
    logic       load_key;
    logic       capture;
    logic [1:0] fill;
    logic       complete;
    logic       cof_step;
    logic       rot_rows;
    logic       det_step;
    logic       inv_load;
    logic       scale_step;
    logic       out_load;
    logic       out_last;
    logic [1:0] row;
    logic [1:0] col;
  } hcm_cmd_t;

  typedef struct packed {
    logic n3;
    logic decrypt;
  } hcm_stat_t;

  // x mod 26 for x < 2048
  function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
    logic [18:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 19'(x) * 19'(RECIP);
    q    = prod[18:12];
    r    = x - 11'(q) * 11'(MODULUS);
    if (r >= 11'(MODULUS)) begin
      r = r - 11'(MODULUS);
    end
    return r[LETTER_W-1:0];
  endfunction

  // 5-bit value mod 26
  function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] x);
    return (x >= 5'(MODULUS)) ? x - 5'(MODULUS) : x;
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic logic [LETTER_W-1:0] det_inv(input logic [LETTER_W-1:0] d);
    logic [LETTER_W-1:0] r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/hcm_datapath.sv -----
// ----------------------------------------------------------------------------
// Hill cipher datapath
// Configuration registers, key matrix with cofactor rotation, working key,
// determinant/inverse, block vector and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hill_cipher_mod26_unit_macros.svh"

module hcm_datapath import hcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic [LETTER_W-1:0]  letter,
  input  hcm_cmd_t             cmd,
  output hcm_stat_t            stat,
  output logic [LETTER_W-1:0]  out_letter,
  output logic                 last,
  output logic                 error
);

  logic [KEY_W-1:0]    key_cfg;
  logic                size_cfg;
  logic                mode_cfg;

  logic [LETTER_W-1:0] key_e  [9];
  logic [LETTER_W-1:0] m_load [3][3];
  logic [LETTER_W-1:0] m_rot  [3][3];
  logic [LETTER_W-1:0] m      [3][3];
  logic [LETTER_W-1:0] wkey   [3][3];
  logic [LETTER_W-1:0] v      [3];
  logic [LETTER_W-1:0] det;
  logic [LETTER_W-1:0] dinv;
  logic                key_invalid;

  logic [LETTER_W-1:0] lred;
  logic [LETTER_W-1:0] wsel;
  logic [LETTER_W-1:0] cof_val;
  logic [LETTER_W-1:0] det_next;
  logic [LETTER_W-1:0] scaled;
  logic [LETTER_W-1:0] row_sum;
  logic [9:0]          p1, p2, pdet, pscl;
  logic [9:0]          pr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_cfg  <= '0;
      size_cfg <= 1'b0;
      mode_cfg <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY:  key_cfg  <= cfg_data;
        CFG_SIZE: size_cfg <= cfg_data[0];
        CFG_MODE: mode_cfg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign stat.n3      = size_cfg;
  assign stat.decrypt = mode_cfg;

  // key entries reduced; 2x2 key padded with a unit corner so the 3x3
  // adjugate path yields the 2x2 inverse in its upper-left block
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      key_e[i] = red26(key_cfg[LETTER_W*i +: LETTER_W]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_load[i][j] = size_cfg ? key_e[3*i+j] : '0;
      end
    end
    if (!size_cfg) begin
      m_load[0][0] = key_e[0];
      m_load[0][1] = key_e[1];
      m_load[1][0] = key_e[2];
      m_load[1][1] = key_e[3];
      m_load[2][2] = 5'd1;
    end
  end

  // column rotate every step, rows too at the end of a row pass
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_rot[i][j] = cmd.rot_rows ? m[(i == 2) ? 0 : i + 1][(j == 2) ? 0 : j + 1]
                                   : m[i][(j == 2) ? 0 : j + 1];
      end
    end
  end

  assign lred = red26(letter);
  assign wsel = wkey[cmd.row][cmd.col];

  assign p1      = 10'(m[1][1]) * 10'(m[2][2]);
  assign p2      = 10'(m[1][2]) * 10'(m[2][1]);
  assign cof_val = mod26(11'(p1) + 11'(COF_BIAS) - 11'(p2));

  assign pdet     = 10'(m[0][cmd.row]) * 10'(wsel);
  assign det_next = mod26(11'(det) + 11'(pdet));

  assign pscl   = 10'(dinv) * 10'(wsel);
  assign scaled = mod26(11'(pscl));

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pr[j] = 10'(wkey[cmd.row][j]) * 10'(v[j]);
    end
    row_sum = mod26(11'(pr[0]) + 11'(pr[1]) + 11'(pr[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      m <= m_load;
    end else if (cmd.cof_step) begin
      m <= m_rot;
    end
  end

  // cofactor (i,j) lands at [j][i]: the adjugate, scaled in place later
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      wkey <= m_load;
    end else if (cmd.cof_step) begin
      wkey[cmd.row][cmd.col] <= cof_val;
    end else if (cmd.scale_step) begin
      wkey[cmd.row][cmd.col] <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      det <= '0;
    end else if (cmd.det_step) begin
      det <= det_next;
    end
    if (cmd.inv_load) begin
      dinv <= det_inv(det);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_invalid <= 1'b0;
    end else if (cmd.load_key) begin
      key_invalid <= 1'b0;
    end else if (cmd.inv_load) begin
      key_invalid <= (det_inv(det) == 5'd0);
    end
  end

  // block vector: new letter at the fill slot, zero pad above it on close
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int j = 0; j < 3; j++) begin
        if (2'(j) == cmd.fill) begin
          v[j] <= lred;
        end else if (cmd.complete && (2'(j) > cmd.fill)) begin
          v[j] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_letter <= key_invalid ? '0 : row_sum;
      last       <= cmd.out_last;
      error      <= key_invalid;
    end
  end

  `HCM_ASSERT_NXT(a_inv_flag, cmd.inv_load, key_invalid == (dinv == 5'd0),
                  "invalid flag disagrees with determinant inverse")
  `HCM_ASSERT_NXT(a_enc_valid, cmd.load_key && !mode_cfg, !key_invalid,
                  "key flagged invalid on an encrypt message")

endmodule

// ----- hw/rtl/hcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Hill cipher controller
// Letter intake, block fill tracking, key setup sequencing and the
// output beat sequencing for each completed block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hill_cipher_mod26_unit_macros.svh"

module hcm_ctrl import hcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      final_req,
  output logic      out_valid,
  input  logic      out_ready,
  input  hcm_stat_t stat,
  output hcm_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COF   = 3'd1;
  localparam logic [2:0] ST_DET   = 3'd2;
  localparam logic [2:0] ST_INV   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state;
  logic [1:0] fill;
  logic       at_start;
  logic       n3;
  logic       fin_blk;
  logic       done_blk;
  logic [1:0] a;
  logic [1:0] b;
  logic [1:0] row;
  logic       out_valid_r;

  logic       accept;
  logic       n3_eff;
  logic       complete;
  logic [1:0] last_row;
  logic       out_load;
  logic       b_wrap;
  logic       ab_end;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign n3_eff    = at_start ? stat.n3 : n3;
  assign complete  = final_req || (n3_eff ? (fill == 2'd2) : (fill == 2'd1));
  assign last_row  = n3 ? 2'd2 : 2'd1;
  assign out_load  = (state == ST_OUT) && (!out_valid_r || out_ready);
  assign b_wrap    = (b == 2'd2);
  assign ab_end    = (a == 2'd2) && b_wrap;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= 2'd0;
      at_start    <= 1'b1;
      n3          <= 1'b0;
      fin_blk     <= 1'b0;
      done_blk    <= 1'b0;
      a           <= 2'd0;
      b           <= 2'd0;
      row         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fin_blk  <= final_req;
            done_blk <= complete;
            fill     <= complete ? 2'd0 : fill + 2'd1;
            at_start <= final_req;
            a        <= 2'd0;
            b        <= 2'd0;
            row      <= 2'd0;
            if (at_start) begin
              n3 <= stat.n3;
            end
            if (at_start && stat.decrypt) begin
              state <= ST_COF;
            end else if (complete) begin
              state <= ST_OUT;
            end
          end
        end
        ST_COF, ST_SCALE: begin
          if (b_wrap) begin
            b <= 2'd0;
            a <= ab_end ? 2'd0 : a + 2'd1;
          end else begin
            b <= b + 2'd1;
          end
          if (ab_end) begin
            if (state == ST_COF) begin
              state <= ST_DET;
            end else begin
              state <= done_blk ? ST_OUT : ST_IDLE;
            end
          end
        end
        ST_DET: begin
          if (b_wrap) begin
            b     <= 2'd0;
            state <= ST_INV;
          end else begin
            b <= b + 2'd1;
          end
        end
        ST_INV: begin
          state <= ST_SCALE;
        end
        ST_OUT: begin
          if (out_load) begin
            if (row == last_row) begin
              row   <= 2'd0;
              state <= ST_IDLE;
            end else begin
              row <= row + 2'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load_key   = accept && at_start;
    cmd.capture    = accept;
    cmd.fill       = fill;
    cmd.complete   = complete;
    cmd.cof_step   = (state == ST_COF);
    cmd.rot_rows   = b_wrap;
    cmd.det_step   = (state == ST_DET);
    cmd.inv_load   = (state == ST_INV);
    cmd.scale_step = (state == ST_SCALE);
    cmd.out_load   = out_load;
    cmd.out_last   = fin_blk && (row == last_row);
    case (state)
      ST_COF: begin
        cmd.row = b;
        cmd.col = a;
      end
      ST_DET: begin
        cmd.row = b;
        cmd.col = 2'd0;
      end
      ST_SCALE: begin
        cmd.row = a;
        cmd.col = b;
      end
      ST_OUT: begin
        cmd.row = row;
        cmd.col = 2'd0;
      end
      default: begin
        cmd.row = 2'd0;
        cmd.col = 2'd0;
      end
    endcase
  end

  `HCM_ASSERT_IMP(a_fill_start, at_start, fill == 2'd0,
                  "letters pending at message start")
  `HCM_ASSERT_IMP(a_fill_n2, !at_start && !n3, fill != 2'd2,
                  "2x2 block holds too many letters")
  `HCM_ASSERT_IMP(a_cnt_range, state == ST_COF || state == ST_SCALE,
                  a != 2'd3 && b != 2'd3, "setup counter out of range")
  `HCM_ASSERT_NXT(a_blk_done, out_load && row == last_row, state == ST_IDLE,
                  "block did not close after its last beat")

endmodule

// ----- hw/rtl/hill_cipher_mod26_unit.sv -----
// ----------------------------------------------------------------------------
// Hill cipher mod-26 unit
// Letters 0..25 stream in, one per beat, and are gathered into blocks of 2
// or 3 (key_size, latched with the key and mode on a message's first
// letter). The letter that closes a block (full, or cut short by final_req
// and zero padded) is followed by n output beats from a single row-product
// unit, one row per cycle while out_ready allows, with intake paused until
// the last row is loaded into the output register. In decrypt mode the
// first letter of a message adds a key setup through one cofactor unit:
// 9 cofactors, 3 determinant terms, the inverse lookup and 9 adjugate
// scalings. A decrypt key with no inverse mod 26 yields zero letters with
// error set for the whole message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hill_cipher_mod26_unit import hcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LETTER_W-1:0]  letter,
  input  logic                 final_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LETTER_W-1:0]  out_letter,
  output logic                 last,
  output logic                 error
);

  hcm_cmd_t  cmd;
  hcm_stat_t stat;

  hcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .final_req (final_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hcm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .letter     (letter),
    .cmd        (cmd),
    .stat       (stat),
    .out_letter (out_letter),
    .last       (last),
    .error      (error)
  );

endmodule
